// File: sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define CTD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ctd assertion failed");

// next-cycle implication, off while in reset
`define CTD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ctd assertion failed");

// state in the cycle after reset
`define CTD_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("ctd assertion failed");

`endif

// File: sv/ctd_pkg.sv
package ctd_pkg;

  localparam int CTD_SPLIT_STAGES = 21;
  localparam int CTD_STAGES = 25;

  localparam longint NANOS_PER_SECOND = 1000000000;
  localparam longint SEC_PER_DAY = 86400;
  localparam longint SEC_PER_HOUR = 3600;
  localparam longint SEC_PER_MIN = 60;
  localparam longint DAYS_PER_ERA = 146097;
  localparam longint DAYS_PER_4Y = 1460;
  localparam longint DAYS_PER_YEAR = 365;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  mon;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  min;
    logic [5:0]  sec;
    logic [29:0] nsec;
  } ctd_civil_t;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  function automatic logic is_leap(input logic [11:0] year);
    logic century;
    century = (year == 12'd1700) || (year == 12'd1800) || (year == 12'd1900) ||
              (year == 12'd2100) || (year == 12'd2200);
    return (year[1:0] == 2'b00) && !century;
  endfunction

  function automatic logic [4:0] month_days(input logic [11:0] year,
                                            input logic [3:0] mon);
    logic [4:0] len;
    if (mon == 4'd1) begin
      len = is_leap(year) ? 5'd29 : 5'd28;
    end else if (mon < 4'd12) begin
      len = MONTH_LEN[mon];
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

  // first day of year of each month, counted from march
  function automatic logic [8:0] mday_base(input logic [3:0] mp);
    logic [8:0] b;
    case (mp)
      4'd0:    b = 9'd0;
      4'd1:    b = 9'd31;
      4'd2:    b = 9'd61;
      4'd3:    b = 9'd92;
      4'd4:    b = 9'd122;
      4'd5:    b = 9'd153;
      4'd6:    b = 9'd184;
      4'd7:    b = 9'd214;
      4'd8:    b = 9'd245;
      4'd9:    b = 9'd275;
      4'd10:   b = 9'd306;
      4'd11:   b = 9'd337;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

endpackage

// File: sv/ctd_div.sv
module ctd_div #(
  parameter int     W   = 64,
  parameter int     QB  = 35,
  parameter int     RW  = 30,
  parameter longint D   = 1000000000,
  parameter int     SPS = 5,
  parameter int     SBW = 1
) (
  input  logic                       clk,
  input  logic [(QB+SPS-1)/SPS-1:0]  en,
  input  logic [W-1:0]               num,
  input  logic [SBW-1:0]             sb_in,
  output logic [QB-1:0]              quot,
  output logic [RW-1:0]              rem,
  output logic [SBW-1:0]             sb_out
);

  localparam int NS = (QB + SPS - 1) / SPS;
  localparam logic [RW:0] DV = (RW+1)'(D);

  logic [RW-1:0]  rem_r [NS];
  logic [QB-1:0]  q_r   [NS];
  logic [QB-1:0]  lo_r  [NS];
  logic [SBW-1:0] sb_r  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [RW-1:0]  rem_i, rem_o;
    logic [QB-1:0]  q_i, q_o, lo_i, lo_o;
    logic [SBW-1:0] sb_i;

    if (k == 0) begin : g_first
      assign rem_i = RW'(num[W-1:QB]);
      assign q_i   = '0;
      assign lo_i  = num[QB-1:0];
      assign sb_i  = sb_in;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign q_i   = q_r[k-1];
      assign lo_i  = lo_r[k-1];
      assign sb_i  = sb_r[k-1];
    end

    always_comb begin
      logic [RW:0] r2;
      rem_o = rem_i;
      q_o   = q_i;
      lo_o  = lo_i;
      r2    = '0;
      for (int j = 0; j < SPS; j++) begin
        if (k * SPS + j < QB) begin
          r2   = {rem_o, lo_o[QB-1]};
          lo_o = {lo_o[QB-2:0], 1'b0};
          if (r2 >= DV) begin
            rem_o = RW'(r2 - DV);
            q_o   = {q_o[QB-2:0], 1'b1};
          end else begin
            rem_o = r2[RW-1:0];
            q_o   = {q_o[QB-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= rem_o;
        q_r[k]   <= q_o;
        lo_r[k]  <= lo_o;
        sb_r[k]  <= sb_i;
      end
    end
  end

  assign quot   = q_r[NS-1];
  assign rem    = rem_r[NS-1];
  assign sb_out = sb_r[NS-1];

endmodule

// File: sv/ctd_split.sv
module ctd_split (
  input  logic                                 clk,
  input  logic [ctd_pkg::CTD_SPLIT_STAGES-1:0] en,
  input  logic [63:0]                          t,
  input  logic                                 tag_in,
  output ctd_pkg::ctd_civil_t                  civ,
  output logic                                 tag_out
);

  import ctd_pkg::*;

  // seconds from biased unsigned time
  logic [34:0] q1;
  logic [29:0] r1;
  logic        tag1;

  ctd_div #(.W(64), .QB(35), .RW(30), .D(NANOS_PER_SECOND), .SPS(5), .SBW(1)) u_div_ns (
    .clk(clk), .en(en[6:0]), .num({~t[63], t[62:0]}), .sb_in(tag_in),
    .quot(q1), .rem(r1), .sb_out(tag1)
  );

  logic        nb;
  logic [29:0] ns1;
  logic [34:0] sbias;

  always_comb begin
    nb    = r1 < 30'd854775808;
    ns1   = nb ? r1 + 30'd145224192 : r1 - 30'd854775808;
    sbias = q1 + 35'd764 - {34'd0, nb};
  end

  logic [18:0] q2;
  logic [16:0] r2;
  logic [30:0] sb2;

  ctd_div #(.W(35), .QB(19), .RW(17), .D(SEC_PER_DAY), .SPS(5), .SBW(31)) u_div_day (
    .clk(clk), .en(en[10:7]), .num(sbias), .sb_in({tag1, ns1}),
    .quot(q2), .rem(r2), .sb_out(sb2)
  );

  logic [4:0]  q3;
  logic [11:0] r3;
  logic [49:0] sb3;

  ctd_div #(.W(17), .QB(5), .RW(12), .D(SEC_PER_HOUR), .SPS(5), .SBW(50)) u_div_hour (
    .clk(clk), .en(en[11:11]), .num(r2), .sb_in({sb2, q2}),
    .quot(q3), .rem(r3), .sb_out(sb3)
  );

  logic [5:0]  q4;
  logic [5:0]  r4;
  logic [54:0] sb4;

  ctd_div #(.W(12), .QB(6), .RW(6), .D(SEC_PER_MIN), .SPS(6), .SBW(55)) u_div_min (
    .clk(clk), .en(en[12:12]), .num(r3), .sb_in({sb3, q3}),
    .quot(q4), .rem(r4), .sb_out(sb4)
  );

  logic [19:0] z;
  logic [47:0] base4;

  always_comb begin
    z     = {1'b0, sb4[23:5]} + 20'd612716;
    base4 = {sb4[54], sb4[53:24], sb4[4:0], q4, r4};
  end

  logic [2:0]  q5;
  logic [17:0] r5;
  logic [47:0] sb5;

  ctd_div #(.W(20), .QB(3), .RW(18), .D(DAYS_PER_ERA), .SPS(5), .SBW(48)) u_div_era (
    .clk(clk), .en(en[13:13]), .num(z), .sb_in(base4),
    .quot(q5), .rem(r5), .sb_out(sb5)
  );

  logic [2:0] c2;
  logic [1:0] kc;

  always_comb begin
    c2 = {2'b00, r5 >= 18'd36524} + {2'b00, r5 >= 18'd73048} +
         {2'b00, r5 >= 18'd109572} + {2'b00, r5 >= 18'd146096};
    kc = 2'(c2 - {2'b00, r5 == 18'd146096});
  end

  logic [6:0]  q6;
  logic [70:0] sb6;

  ctd_div #(.W(18), .QB(7), .RW(11), .D(DAYS_PER_4Y), .SPS(5), .SBW(71)) u_div_4y (
    .clk(clk), .en(en[15:14]), .num(r5), .sb_in({sb5, q5, r5, kc}),
    .quot(q6), .rem(), .sb_out(sb6)
  );

  logic [17:0] nyr;

  assign nyr = sb6[19:2] - {11'd0, q6} + {16'd0, sb6[1:0]};

  logic [8:0]  q7;
  logic [68:0] sb7;

  ctd_div #(.W(18), .QB(9), .RW(9), .D(DAYS_PER_YEAR), .SPS(5), .SBW(69)) u_div_year (
    .clk(clk), .en(en[17:16]), .num(nyr), .sb_in(sb6[70:2]),
    .quot(q7), .rem(), .sb_out(sb7)
  );

  // day of year from year of era
  logic [1:0]  yc;
  logic [17:0] ydays;
  logic [47:0] f3_base;
  logic [2:0]  f3_era;
  logic [8:0]  f3_yoe;
  logic [8:0]  f3_doy;

  always_comb begin
    yc    = {1'b0, q7 >= 9'd100} + {1'b0, q7 >= 9'd200} + {1'b0, q7 >= 9'd300};
    ydays = {9'd0, q7} * 18'd365 + {11'd0, q7[8:2]} - {16'd0, yc};
  end

  always_ff @(posedge clk) begin
    if (en[18]) begin
      f3_base <= sb7[68:21];
      f3_era  <= sb7[20:18];
      f3_yoe  <= q7;
      f3_doy  <= 9'(sb7[17:0] - ydays);
    end
  end

  // month counted from march
  logic [10:0] t5;
  logic [3:0]  mp;
  logic [47:0] f4_base;
  logic [2:0]  f4_era;
  logic [8:0]  f4_yoe;
  logic [8:0]  f4_doy;
  logic [3:0]  f4_mp;

  always_comb begin
    t5 = {f3_doy, 2'b00} + {2'b00, f3_doy} + 11'd2;
    mp = '0;
    for (int k = 1; k < 12; k++) begin
      mp = mp + {3'd0, t5 >= 11'(153 * k)};
    end
  end

  always_ff @(posedge clk) begin
    if (en[19]) begin
      f4_base <= f3_base;
      f4_era  <= f3_era;
      f4_yoe  <= f3_yoe;
      f4_doy  <= f3_doy;
      f4_mp   <= mp;
    end
  end

  ctd_civil_t civ_next;
  logic       late;

  always_comb begin
    late          = f4_mp >= 4'd10;
    civ_next.mday = 5'(f4_doy - mday_base(f4_mp) + 9'd1);
    civ_next.mon  = late ? f4_mp - 4'd10 : f4_mp + 4'd2;
    civ_next.year = {3'd0, f4_yoe} + {9'd0, f4_era} * 12'd400 + {11'd0, late};
    civ_next.hour = f4_base[16:12];
    civ_next.min  = f4_base[11:6];
    civ_next.sec  = f4_base[5:0];
    civ_next.nsec = f4_base[46:17];
  end

  always_ff @(posedge clk) begin
    if (en[20]) begin
      civ     <= civ_next;
      tag_out <= f4_base[47];
    end
  end

endmodule

// File: sv/calendar_time_difference.sv
// Calendar difference of two signed nanosecond UTC timestamps, as years, months,
// days, hours, minutes, seconds and nanoseconds. The later time is the minuend and
// all fields are negated when first_time is the earlier one. Fully pipelined: one
// item per cycle through 25 register stages while diff_stall does not hold the
// output. Most stages are the restoring dividers that split each timestamp into a
// civil date, five or six quotient bits per stage, then three stages of borrow
// subtraction and output. Any stage with no item takes the next one, so a held
// result does not stop intake until the pipe is full. Intake is stalled while rst
// is high.
module calendar_time_difference (
  input  logic               clk,
  input  logic               rst,
  input  logic               time_valid,
  output logic               time_stall,
  input  logic signed [63:0] first_time,
  input  logic signed [63:0] second_time,
  output logic               diff_valid,
  input  logic               diff_stall,
  output logic signed [10:0] diff_years,
  output logic signed [4:0]  diff_months,
  output logic signed [5:0]  diff_days,
  output logic signed [5:0]  diff_hours,
  output logic signed [6:0]  diff_minutes,
  output logic signed [6:0]  diff_seconds,
  output logic signed [30:0] diff_nanos
);

  import ctd_pkg::*;

  localparam int N = CTD_STAGES;
  localparam int SL = CTD_SPLIT_STAGES;

  logic [N-1:0] v;
  logic [N-1:0] en;

  always_comb begin
    en[N-1] = !v[N-1] || !diff_stall;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign time_stall = rst || !en[0];
  assign diff_valid = v[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= time_valid;
      end
      for (int i = 1; i < N; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // order the pair, later time first
  logic        neg0;
  logic [63:0] ta0, tb0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg0 <= first_time < second_time;
      ta0  <= (first_time < second_time) ? second_time : first_time;
      tb0  <= (first_time < second_time) ? first_time : second_time;
    end
  end

  ctd_civil_t ca, cb;
  logic       neg1;

  ctd_split u_split_a (
    .clk(clk), .en(en[SL:1]), .t(ta0), .tag_in(neg0), .civ(ca), .tag_out(neg1)
  );

  ctd_split u_split_b (
    .clk(clk), .en(en[SL:1]), .t(tb0), .tag_in(1'b0), .civ(cb), .tag_out()
  );

  // nanoseconds, seconds, minutes
  logic [30:0] dns;
  logic [7:0]  dsec, dmin;
  logic        bns, bsec;

  always_comb begin
    dns  = {1'b0, ca.nsec} - {1'b0, cb.nsec};
    bns  = dns[30];
    dsec = {2'b00, ca.sec} - {7'd0, bns} - {2'b00, cb.sec};
    bsec = dsec[7];
    dmin = {2'b00, ca.min} - {7'd0, bsec} - {2'b00, cb.min};
  end

  logic [30:0] s1_ns;
  logic [7:0]  s1_sec, s1_min;
  logic        s1_bmin, s1_neg;
  ctd_civil_t  s1_a, s1_b;

  always_ff @(posedge clk) begin
    if (en[SL+1]) begin
      s1_ns   <= bns ? dns + 31'd1000000000 : dns;
      s1_sec  <= bsec ? dsec + 8'd60 : dsec;
      s1_min  <= dmin[7] ? dmin + 8'd60 : dmin;
      s1_bmin <= dmin[7];
      s1_neg  <= neg1;
      s1_a    <= ca;
      s1_b    <= cb;
    end
  end

  // hours, days with one month borrow, months, years
  logic [6:0]  dh, dd;
  logic        bh;
  logic [3:0]  monp;
  logic [11:0] yrp, yrq;
  logic [4:0]  dmon;
  logic [12:0] dyr;

  always_comb begin
    dh   = {2'b00, s1_a.hour} - {6'd0, s1_bmin} - {2'b00, s1_b.hour};
    bh   = dh[6];
    dd   = {2'b00, s1_a.mday} - {6'd0, bh} - {2'b00, s1_b.mday};
    monp = s1_a.mon;
    yrp  = s1_a.year;
    if (dd[6]) begin
      if (s1_a.mon == 4'd0) begin
        monp = 4'd11;
        yrp  = s1_a.year - 12'd1;
      end else begin
        monp = s1_a.mon - 4'd1;
      end
      dd = dd + {2'b00, month_days(yrp, monp)};
    end
    dmon = {1'b0, monp} - {1'b0, s1_b.mon};
    yrq  = yrp - {11'd0, dmon[4]};
    if (dmon[4]) begin
      dmon = dmon + 5'd12;
    end
    dyr = {1'b0, yrq} - {1'b0, s1_b.year};
  end

  logic [30:0] s2_ns;
  logic [7:0]  s2_sec, s2_min;
  logic [6:0]  s2_hour, s2_day;
  logic [4:0]  s2_mon;
  logic [12:0] s2_yr;
  logic        s2_neg;

  always_ff @(posedge clk) begin
    if (en[SL+2]) begin
      s2_ns   <= s1_ns;
      s2_sec  <= s1_sec;
      s2_min  <= s1_min;
      s2_hour <= bh ? dh + 7'd24 : dh;
      s2_day  <= dd;
      s2_mon  <= dmon;
      s2_yr   <= dyr;
      s2_neg  <= s1_neg;
    end
  end

  // sign and output
  logic [30:0] n_ns;
  logic [7:0]  n_sec, n_min;
  logic [6:0]  n_hour, n_day;
  logic [4:0]  n_mon;
  logic [12:0] n_yr;

  always_comb begin
    n_ns   = s2_neg ? -s2_ns : s2_ns;
    n_sec  = s2_neg ? -s2_sec : s2_sec;
    n_min  = s2_neg ? -s2_min : s2_min;
    n_hour = s2_neg ? -s2_hour : s2_hour;
    n_day  = s2_neg ? -s2_day : s2_day;
    n_mon  = s2_neg ? -s2_mon : s2_mon;
    n_yr   = s2_neg ? -s2_yr : s2_yr;
  end

  always_ff @(posedge clk) begin
    if (en[N-1]) begin
      diff_years   <= n_yr[10:0];
      diff_months  <= n_mon;
      diff_days    <= n_day[5:0];
      diff_hours   <= n_hour[5:0];
      diff_minutes <= n_min[6:0];
      diff_seconds <= n_sec[6:0];
      diff_nanos   <= n_ns;
    end
  end

endmodule

// File: sv/ctd_checker.sv
`include "assert_macros.svh"

module ctd_checker (
  input logic               clk,
  input logic               rst,
  input logic               time_valid,
  input logic               time_stall,
  input logic signed [63:0] first_time,
  input logic signed [63:0] second_time,
  input logic               diff_valid,
  input logic               diff_stall,
  input logic signed [10:0] diff_years,
  input logic signed [4:0]  diff_months,
  input logic signed [5:0]  diff_days,
  input logic signed [5:0]  diff_hours,
  input logic signed [6:0]  diff_minutes,
  input logic signed [6:0]  diff_seconds,
  input logic signed [30:0] diff_nanos
);

  // a waiting result stays until taken
  `CTD_ASSERT_NXT(a_hold, diff_valid && diff_stall, diff_valid)

  // pipe starts empty
  `CTD_ASSERT_RST(a_reset, !diff_valid)

  // an empty output slot never blocks intake
  `CTD_ASSERT_IMP(a_no_stall, !diff_valid, !time_stall)

  // a negative hour field comes with a minute field that is not positive
  `CTD_ASSERT_IMP(a_sign, diff_valid && diff_hours[5], diff_minutes[6] || diff_minutes == 7'sd0)

endmodule

bind calendar_time_difference ctd_checker u_ctd_checker (.*);
